/* rtl/core/tvs_pkg.sv */
// Shared constants and types of the torque vectoring split block.
package tvs_pkg;

    localparam int QW = 13;
    localparam int DIV_STAGES = 7;
    localparam logic [QW-1:0] Q_ONE = 13'd4096;
    localparam logic [QW-1:0] Q_HALF = 13'd2048;
    localparam int SPEED_OFFSET = 64000;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    typedef enum logic [CFG_IW-1:0] {
        CFG_MAX_RPM       = 3'd0,
        CFG_MAX_REGEN     = 3'd1,
        CFG_DEF_SPLIT     = 3'd2,
        CFG_ALT_SPLIT     = 3'd3,
        CFG_FR_GAIN       = 3'd4,
        CFG_LR_GAIN       = 3'd5,
        CFG_FRONT_REGEN   = 3'd6,
        CFG_REAR_REGEN    = 3'd7
    } t_cfg_idx;

endpackage

/* rtl/core/torque_vectoring_split.sv */
// Top level: pipelined torque split and speed command for a four-motor drivetrain.
// An accepted input word passes stages 1 and 2, the slip divider, stages 10 and 11 and the output register.
// One word is accepted per cycle while o_stall is low; the seven-stage slip divider sets the depth.
// The whole pipeline holds while a result word is stalled at the output.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
module torque_vectoring_split #(
    parameter int MAX_TORQUE = 2100,
    parameter int RPM_TO_MPS_Q16 = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tvs_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [tvs_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [12:0]                   i_accel_pedal,
    input  logic [12:0]                   i_brake_pedal,
    input  logic signed [15:0]            i_speed_front_left,
    input  logic signed [15:0]            i_speed_front_right,
    input  logic signed [15:0]            i_speed_rear_left,
    input  logic signed [15:0]            i_speed_rear_right,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [14:0]                   o_target_speed,
    output logic [12:0]                   o_torque_front_left,
    output logic [12:0]                   o_torque_front_right,
    output logic [12:0]                   o_torque_rear_left,
    output logic [12:0]                   o_torque_rear_right
);

    localparam int QW   = tvs_pkg::QW;
    localparam int DS   = tvs_pkg::DIV_STAGES;
    localparam int KW   = $clog2(RPM_TO_MPS_Q16 + 1);
    localparam int PW   = 17 + KW;
    localparam int VW   = PW - 8;
    localparam int SW   = ((VW + 1 > 17) ? VW + 1 : 17) + 2;
    localparam int NDW  = VW + 2;
    localparam int DW   = SW - 1;
    localparam int NW   = NDW + 16;
    localparam int TQW  = $clog2(8191 * MAX_TORQUE + 1);
    localparam int CEIL = (2 * MAX_TORQUE > 8191) ? 8191 : 2 * MAX_TORQUE;
    localparam int FBW  = 28;
    localparam int FPW  = FBW + TQW;
    localparam int RBW  = 26;
    localparam int RPW  = RBW + TQW;
    localparam int RTW  = TQW + 2;
    localparam int RGW  = 25;
    localparam int GPW  = 39;
    localparam int RLW  = RTW + 13;
    localparam logic signed [PW-1:0] K_S = PW'(RPM_TO_MPS_Q16);
    localparam logic signed [SW-1:0] OFF_S = SW'(tvs_pkg::SPEED_OFFSET);

    typedef struct packed {
        logic           drive;
        logic           rlgt;
        logic [TQW-1:0] tq;
        logic [RGW-1:0] tqrg;
    } t_side;

    function automatic logic [12:0] f_sat(input logic [63:0] v);
        return (v > 64'(CEIL)) ? 13'(CEIL) : v[12:0];
    endfunction

    // Configuration registers.
    logic [14:0] r_max_rpm;
    logic [11:0] r_max_regen;
    logic [12:0] r_def;
    logic [12:0] r_alt;
    logic [15:0] r_fr_gain;
    logic [15:0] r_lr_gain;
    logic [13:0] r_fscale;
    logic [13:0] r_rscale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rpm   <= 15'd20000;
            r_max_regen <= 12'd1000;
            r_def       <= 13'd2048;
            r_alt       <= 13'd3072;
            r_fr_gain   <= 16'd4096;
            r_lr_gain   <= 16'd4096;
            r_fscale    <= 14'd4096;
            r_rscale    <= 14'd4096;
        end else if (i_cfg_we) begin
            case (tvs_pkg::t_cfg_idx'(i_cfg_idx))
                tvs_pkg::CFG_MAX_RPM:     r_max_rpm   <= i_cfg_data[14:0];
                tvs_pkg::CFG_MAX_REGEN:   r_max_regen <= i_cfg_data[11:0];
                tvs_pkg::CFG_DEF_SPLIT:   r_def       <= i_cfg_data[12:0];
                tvs_pkg::CFG_ALT_SPLIT:   r_alt       <= i_cfg_data[12:0];
                tvs_pkg::CFG_FR_GAIN:     r_fr_gain   <= i_cfg_data;
                tvs_pkg::CFG_LR_GAIN:     r_lr_gain   <= i_cfg_data;
                tvs_pkg::CFG_FRONT_REGEN: r_fscale    <= i_cfg_data[13:0];
                tvs_pkg::CFG_REAR_REGEN:  r_rscale    <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en = !o_valid || !i_stall;
    assign o_stall = !en;

    // Stage 1: speeds, slip numerators and denominators, torque request.
    logic signed [PW-1:0] c_pfl, c_pfr, c_prl, c_prr;
    logic signed [VW-1:0] c_vfl, c_vfr, c_vrl, c_vrr;
    logic signed [SW-1:0] c_nfr, c_dfr, c_dif, c_srl, c_srr, c_ln, c_ld, c_ldif;
    logic signed [13:0]   c_r;
    logic                 c_rlgt;

    always_comb begin
        c_pfl = PW'(i_speed_front_left) * K_S;
        c_pfr = PW'(i_speed_front_right) * K_S;
        c_prl = PW'(i_speed_rear_left) * K_S;
        c_prr = PW'(i_speed_rear_right) * K_S;
        c_vfl = VW'(c_pfl >>> 8);
        c_vfr = VW'(c_pfr >>> 8);
        c_vrl = VW'(c_prl >>> 8);
        c_vrr = VW'(c_prr >>> 8);
        c_nfr = SW'(c_vrl) + SW'(c_vrr) + OFF_S;
        c_dfr = SW'(c_vfl) + SW'(c_vfr) + OFF_S;
        c_dif = c_nfr - c_dfr;
        c_srl = SW'(c_vrl) + OFF_S;
        c_srr = SW'(c_vrr) + OFF_S;
        c_rlgt = c_vrl > c_vrr;
        c_ln = c_rlgt ? c_srl : c_srr;
        c_ld = c_rlgt ? c_srr : c_srl;
        c_ldif = c_ln - c_ld;
        c_r = $signed({1'b0, i_accel_pedal}) - $signed({1'b0, i_brake_pedal});
    end

    logic            r1_valid;
    logic            r1_drive;
    logic            r1_rlgt;
    logic [TQW-1:0]  r1_tq;
    logic [12:0]     r1_mag;
    logic [NDW-1:0]  r1_frnd;
    logic [DW-1:0]   r1_frd;
    logic [NDW-1:0]  r1_lrnd;
    logic [DW-1:0]   r1_lrd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_drive <= !c_r[13];
            r1_rlgt  <= c_rlgt;
            r1_tq    <= TQW'(i_accel_pedal - i_brake_pedal) * TQW'(MAX_TORQUE);
            r1_mag   <= i_brake_pedal - i_accel_pedal;
            r1_frnd  <= (c_dfr > SW'(0) && c_dif > SW'(0)) ? NDW'(c_dif) : '0;
            r1_frd   <= DW'(c_dfr);
            r1_lrnd  <= (c_ld > SW'(0) && c_ldif > SW'(0)) ? NDW'(c_ldif) : '0;
            r1_lrd   <= DW'(c_ld);
        end
    end

    // Stage 2: gain products and regen torque.
    logic            r2_valid;
    logic [NW-1:0]   r2_frn;
    logic [DW-1:0]   r2_frd;
    logic [NW-1:0]   r2_lrn;
    logic [DW-1:0]   r2_lrd;
    t_side           r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_frn       <= NW'(r1_frnd) * NW'(r_fr_gain);
            r2_frd       <= r1_frd;
            r2_lrn       <= NW'(r1_lrnd) * NW'(r_lr_gain);
            r2_lrd       <= r1_lrd;
            r2_side.drive <= r1_drive;
            r2_side.rlgt  <= r1_rlgt;
            r2_side.tq    <= r1_tq;
            r2_side.tqrg  <= RGW'(r_max_regen) * RGW'(r1_mag);
        end
    end

    // Slip dividers and the matching side line.
    logic [QW-1:0] d_frq, d_lrq;
    logic          d_frov, d_lrov;

    tvs_slip_div #(.NW(NW), .DW(DW)) u_fr_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r2_frn),
        .i_den  (r2_frd),
        .o_quot (d_frq),
        .o_ovf  (d_frov)
    );

    tvs_slip_div #(.NW(NW), .DW(DW)) u_lr_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r2_lrn),
        .i_den  (r2_lrd),
        .o_quot (d_lrq),
        .o_ovf  (d_lrov)
    );

    logic  r_sv [DS];
    t_side r_sd [DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DS; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (en) begin
            r_sv[0] <= r2_valid;
            for (int s = 1; s < DS; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r2_side;
            for (int s = 1; s < DS; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    // Stage 10: clamp slips, blend the splits, scale regen.
    t_side                c_sd;
    logic [QW-1:0]        c_sfr, c_slr, c_ms, c_p;
    logic signed [13:0]   c_dc, c_ac;
    logic signed [FBW-1:0] c_fb;
    logic [RBW-1:0]       c_rb;

    always_comb begin
        c_sd  = r_sd[DS-1];
        c_sfr = (d_frov || d_frq > tvs_pkg::Q_ONE) ? tvs_pkg::Q_ONE : d_frq;
        c_slr = (d_lrov || d_lrq > tvs_pkg::Q_HALF) ? tvs_pkg::Q_HALF : d_lrq;
        c_p   = c_sd.rlgt ? tvs_pkg::Q_HALF + c_slr : tvs_pkg::Q_HALF - c_slr;
        c_ms  = tvs_pkg::Q_ONE - c_sfr;
        c_dc  = $signed({1'b0, tvs_pkg::Q_ONE}) - $signed({1'b0, r_def});
        c_ac  = $signed({1'b0, tvs_pkg::Q_ONE}) - $signed({1'b0, r_alt});
        c_fb  = FBW'(c_dc) * $signed(FBW'(c_ms)) + FBW'(c_ac) * $signed(FBW'(c_sfr));
        c_rb  = RBW'(r_def) * RBW'(c_ms) + RBW'(r_alt) * RBW'(c_sfr);
    end

    logic                  r10_valid;
    logic                  r10_drive;
    logic [TQW-1:0]        r10_tq;
    logic signed [FBW-1:0] r10_fb;
    logic [RBW-1:0]        r10_rb;
    logic [QW-1:0]         r10_p;
    logic [GPW-1:0]        r10_ftr;
    logic [GPW-1:0]        r10_rtr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_valid <= 1'b0;
        end else if (en) begin
            r10_valid <= r_sv[DS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_drive <= c_sd.drive;
            r10_tq    <= c_sd.tq;
            r10_fb    <= c_fb;
            r10_rb    <= c_rb;
            r10_p     <= c_p;
            r10_ftr   <= GPW'(c_sd.tqrg) * GPW'(r_fscale);
            r10_rtr   <= GPW'(c_sd.tqrg) * GPW'(r_rscale);
        end
    end

    // Stage 11: apply the torque request to the blends.
    logic [RPW-1:0] c_rprod;
    assign c_rprod = RPW'(r10_rb) * RPW'(r10_tq);

    logic                  r11_valid;
    logic                  r11_drive;
    logic signed [FPW-1:0] r11_fprod;
    logic [RTW-1:0]        r11_rtot;
    logic [QW-1:0]         r11_p;
    logic [GPW-1:0]        r11_ftr;
    logic [GPW-1:0]        r11_rtr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_valid <= 1'b0;
        end else if (en) begin
            r11_valid <= r10_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_drive <= r10_drive;
            r11_fprod <= FPW'(r10_fb) * $signed(FPW'(r10_tq));
            r11_rtot  <= RTW'(c_rprod >> 24);
            r11_p     <= r10_p;
            r11_ftr   <= r10_ftr;
            r11_rtr   <= r10_rtr;
        end
    end

    // Stage 12: left/right share, saturation and the output register.
    logic [RLW-1:0] c_rlp, c_rrp;
    logic [12:0]    c_ft, c_rl, c_rr;

    always_comb begin
        c_rlp = RLW'(r11_rtot) * RLW'(tvs_pkg::Q_ONE - r11_p);
        c_rrp = RLW'(r11_rtot) * RLW'(r11_p);
        c_ft  = (r11_fprod > FPW'(0)) ? f_sat(64'(r11_fprod[FPW-2:36])) : 13'd0;
        c_rl  = f_sat(64'(c_rlp >> 23));
        c_rr  = f_sat(64'(c_rrp >> 23));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r11_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r11_drive) begin
                o_target_speed       <= r_max_rpm;
                o_torque_front_left  <= c_ft;
                o_torque_front_right <= c_ft;
                o_torque_rear_left   <= c_rl;
                o_torque_rear_right  <= c_rr;
            end else begin
                o_target_speed       <= '0;
                o_torque_front_left  <= f_sat(64'(r11_ftr >> 24));
                o_torque_front_right <= f_sat(64'(r11_ftr >> 24));
                o_torque_rear_left   <= f_sat(64'(r11_rtr >> 24));
                o_torque_rear_right  <= f_sat(64'(r11_rtr >> 24));
            end
        end
    end

endmodule

/* rtl/core/tvs_slip_div.sv */
// Pipelined restoring divider for slip ratios: stage 0 tests overflow and one quotient bit, later stages two each.
module tvs_slip_div #(
    parameter int NW = 30,
    parameter int DW = 20
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [NW-1:0]            i_num,
    input  logic [DW-1:0]            i_den,
    output logic [tvs_pkg::QW-1:0]   o_quot,
    output logic                     o_ovf
);

    localparam int ST = tvs_pkg::DIV_STAGES;
    localparam int QW = tvs_pkg::QW;
    localparam int RW = ((NW > DW + QW + 1) ? NW : DW + QW + 1) + 1;

    logic [RW-1:0] r_rem [ST];
    logic [RW-1:0] n_rem [ST];
    logic [RW-1:0] a_rem [ST];
    logic [DW-1:0] r_den [ST];
    logic [DW-1:0] a_den [ST];
    logic [QW-1:0] r_quot [ST];
    logic [QW-1:0] n_quot [ST];
    logic [QW-1:0] a_quot [ST];
    logic          r_ovf [ST];
    logic          n_ovf [ST];
    logic          a_ovf [ST];

    always_comb begin
        logic [RW-1:0] c_rem;
        logic [RW-1:0] c_sub;
        logic [QW-1:0] c_quot;
        logic          c_ovf;
        int            k;
        a_rem[0]  = RW'(i_num);
        a_den[0]  = i_den;
        a_quot[0] = '0;
        a_ovf[0]  = 1'b0;
        for (int s = 1; s < ST; s++) begin
            a_rem[s]  = r_rem[s-1];
            a_den[s]  = r_den[s-1];
            a_quot[s] = r_quot[s-1];
            a_ovf[s]  = r_ovf[s-1];
        end
        for (int s = 0; s < ST; s++) begin
            c_rem  = a_rem[s];
            c_quot = a_quot[s];
            c_ovf  = a_ovf[s];
            for (int b = 0; b < 2; b++) begin
                k = QW - 2 * s - b;
                c_sub = RW'(a_den[s]) << k;
                if (!c_ovf && c_rem >= c_sub) begin
                    if (k == QW) begin
                        c_ovf = 1'b1;
                    end else begin
                        c_rem  = c_rem - c_sub;
                        c_quot = c_quot | (QW'(1) << k);
                    end
                end
            end
            n_rem[s]  = c_rem;
            n_quot[s] = c_quot;
            n_ovf[s]  = c_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < ST; s++) begin
                r_rem[s]  <= n_rem[s];
                r_den[s]  <= a_den[s];
                r_quot[s] <= n_quot[s];
                r_ovf[s]  <= n_ovf[s];
            end
        end
    end

    assign o_quot = r_quot[ST-1];
    assign o_ovf  = r_ovf[ST-1];

endmodule

/* rtl/core/tvs_checker.sv */
// Port-level checker for the torque vectoring split block and its bind.
module tvs_checker #(
    parameter int MAX_TORQUE = 2100
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_stall,
    input logic        o_valid,
    input logic [12:0] o_torque_front_left,
    input logic [12:0] o_torque_front_right,
    input logic [12:0] o_torque_rear_left,
    input logic [12:0] o_torque_rear_right
);

    localparam int CEIL = (2 * MAX_TORQUE > 8191) ? 8191 : 2 * MAX_TORQUE;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_torque_rear_left)
            && $stable(o_torque_rear_right))
        else $error("stalled result word changed");

    a_stall_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output stall");

    a_front_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_torque_front_left == o_torque_front_right)
        else $error("front torques differ");

    a_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_torque_front_left <= 13'(CEIL) && o_torque_rear_left <= 13'(CEIL)
            && o_torque_rear_right <= 13'(CEIL))
        else $error("torque above ceiling");

endmodule

bind torque_vectoring_split tvs_checker #(.MAX_TORQUE(MAX_TORQUE)) u_tvs_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_stall              (i_stall),
    .o_stall              (o_stall),
    .o_valid              (o_valid),
    .o_torque_front_left  (o_torque_front_left),
    .o_torque_front_right (o_torque_front_right),
    .o_torque_rear_left   (o_torque_rear_left),
    .o_torque_rear_right  (o_torque_rear_right)
);
